>>> design/rmms_pkg.sv
// ----------------------------------------------------------------------------
// rmms_pkg
// shared types, widths and codes of the region color statistics block
// ----------------------------------------------------------------------------
package rmms_pkg;

    localparam int PIX_W   = 8;
    localparam int COORD_W = 12;
    localparam int ROI_W   = 13;
    localparam int SUM_W   = 32;
    localparam int SQ_W    = 40;
    localparam int CNT_W   = 25;
    localparam int MEAN_W  = 16;
    localparam int RATIO_W = 24;
    localparam int PROD_W  = 64;
    localparam int DIVD_W  = 80;
    localparam int DIVS_W  = 32;
    localparam int ROOT_W  = 32;
    localparam int STEP_W  = 7;
    localparam int IDX_W   = 3;

    localparam logic [STEP_W-1:0] DIV_STEPS  = 7'd80;
    localparam logic [STEP_W-1:0] MUL_STEPS  = 7'd32;
    localparam logic [STEP_W-1:0] SQRT_STEPS = 7'd16;

    // register indexes
    localparam logic [IDX_W-1:0] CFG_ROI_X        = 3'd0;
    localparam logic [IDX_W-1:0] CFG_ROI_Y        = 3'd1;
    localparam logic [IDX_W-1:0] CFG_ROI_WIDTH    = 3'd2;
    localparam logic [IDX_W-1:0] CFG_ROI_HEIGHT   = 3'd3;
    localparam logic [IDX_W-1:0] CFG_PIXEL_FORMAT = 3'd4;

    // pixel formats
    localparam logic [1:0] FMT_GRAY = 2'd0;
    localparam logic [1:0] FMT_RGB  = 2'd1;
    localparam logic [1:0] FMT_BGR  = 2'd2;

    // channel select
    localparam logic [1:0] CH_RED   = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_BLUE  = 2'd2;

    typedef enum logic [2:0] {
        OP_MEAN     = 3'd0,
        OP_SQ_MUL   = 3'd1,
        OP_NSQ_MUL  = 3'd2,
        OP_VAR_DIV1 = 3'd3,
        OP_VAR_DIV2 = 3'd4,
        OP_SQRT     = 3'd5,
        OP_RATIO_R  = 3'd6,
        OP_RATIO_B  = 3'd7
    } op_t;

    typedef struct packed {
        logic       load;
        logic       step;
        logic       store;
        logic       emit;
        op_t        op;
        logic [1:0] chan;
    } rmms_cmd_t;

    typedef struct packed {
        logic [ROI_W-1:0] roi_x;
        logic [ROI_W-1:0] roi_y;
        logic [ROI_W-1:0] roi_width;
        logic [ROI_W-1:0] roi_height;
        logic [1:0]       pixel_format;
    } rmms_cfg_t;

    typedef struct packed {
        logic               ok;
        logic               ratios_valid;
        logic [CNT_W-1:0]   pixel_total;
        logic [MEAN_W-1:0]  red_mean;
        logic [MEAN_W-1:0]  green_mean;
        logic [MEAN_W-1:0]  blue_mean;
        logic [MEAN_W-1:0]  red_std;
        logic [MEAN_W-1:0]  green_std;
        logic [MEAN_W-1:0]  blue_std;
        logic [RATIO_W-1:0] red_over_green;
        logic [RATIO_W-1:0] blue_over_green;
    } rmms_result_t;

endpackage

>>> design/roi_rgb_mean_std_stats.sv
// ----------------------------------------------------------------------------
// roi_rgb_mean_std_stats
// per-frame mean, std deviation and color ratios over a pixel region
// ----------------------------------------------------------------------------
// throughput: one pixel per cycle inside a frame
// after the frame's last pixel is taken: per channel a mean division, two
//   32-step multiplies, two variance divisions and a 16-step root, then two
//   ratio divisions
// input stalls for that whole sequence, longer while the output register is held
// reset: registers return to defaults, accumulators clear, output empty
module roi_rgb_mean_std_stats import rmms_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    // configuration write channel
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [IDX_W-1:0]   cfg_index,
    input  logic [ROI_W-1:0]   cfg_data,
    // pixel stream
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [47:0]        s_tdata,   // chan_a, chan_b, chan_c, col, row
    input  logic               s_tlast,   // frame_last
    // result stream
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [175:0]       m_tdata,   // pixel_total, red/green/blue_mean,
                                          // red/green/blue_std, red_over_green,
                                          // blue_over_green, zero fill
    output logic [1:0]         m_tuser    // ok, ratios_valid
);

    rmms_cfg_t    cfg_reg;
    rmms_cmd_t    cmd;
    rmms_result_t result;

    logic pix_en;
    logic frame_done;
    logic out_free;
    logic in_ready;

    // config registers, always ready
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.roi_x        <= '0;
            cfg_reg.roi_y        <= '0;
            cfg_reg.roi_width    <= 13'd4096;
            cfg_reg.roi_height   <= 13'd4096;
            cfg_reg.pixel_format <= FMT_RGB;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_ROI_X:        cfg_reg.roi_x        <= cfg_data;
                CFG_ROI_Y:        cfg_reg.roi_y        <= cfg_data;
                CFG_ROI_WIDTH:    cfg_reg.roi_width    <= cfg_data;
                CFG_ROI_HEIGHT:   cfg_reg.roi_height   <= cfg_data;
                CFG_PIXEL_FORMAT: cfg_reg.pixel_format <= cfg_data[1:0];
                default:          ;
            endcase
        end
    end

    // pixel request handshake
    assign s_tready   = in_ready;
    assign pix_en     = s_tvalid && s_tready;
    assign frame_done = pix_en && s_tlast;

    rmms_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .frame_done (frame_done),
        .out_free   (out_free),
        .in_ready   (in_ready),
        .cmd        (cmd)
    );

    rmms_dp u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .pix_en  (pix_en),
        .chan_a  (s_tdata[7:0]),
        .chan_b  (s_tdata[15:8]),
        .chan_c  (s_tdata[23:16]),
        .col     (s_tdata[35:24]),
        .row     (s_tdata[47:36]),
        .cmd     (cmd),
        .result  (result)
    );

    // output register, holds one result request until taken
    logic         m_tvalid_reg;
    logic [175:0] m_tdata_reg;
    logic [1:0]   m_tuser_reg;

    assign out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_tdata_reg <= {7'd0,
                            result.blue_over_green, result.red_over_green,
                            result.blue_std, result.green_std, result.red_std,
                            result.blue_mean, result.green_mean, result.red_mean,
                            result.pixel_total};
            m_tuser_reg <= {result.ratios_valid, result.ok};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    a_emit_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |=> m_tvalid)
        else $error("result not presented after emit");

endmodule

>>> design/rmms_ctrl.sv
// ----------------------------------------------------------------------------
// rmms_ctrl
// sequencer for the end-of-frame arithmetic
// ----------------------------------------------------------------------------
module rmms_ctrl import rmms_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      frame_done,
    input  logic      out_free,
    output logic      in_ready,
    output rmms_cmd_t cmd
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_LOAD  = 5'b00010,
        ST_STEP  = 5'b00100,
        ST_STORE = 5'b01000,
        ST_EMIT  = 5'b10000
    } state_t;

    state_t              state_reg, state_next;
    op_t                 op_reg, op_next;
    logic [1:0]          chan_reg, chan_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [STEP_W-1:0]   step_limit;

    always_comb begin
        unique case (op_reg) inside
            OP_SQ_MUL, OP_NSQ_MUL: step_limit = MUL_STEPS;
            OP_SQRT:               step_limit = SQRT_STEPS;
            default:               step_limit = DIV_STEPS;
        endcase
    end

    always_comb begin
        state_next = state_reg;
        op_next    = op_reg;
        chan_next  = chan_reg;
        step_next  = step_reg;
        cmd        = '0;
        cmd.op     = op_reg;
        cmd.chan   = chan_reg;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (frame_done) begin
                    state_next = ST_LOAD;
                    op_next    = OP_MEAN;
                    chan_next  = CH_RED;
                end
            end
            ST_LOAD: begin
                cmd.load   = 1'b1;
                step_next  = '0;
                state_next = ST_STEP;
            end
            ST_STEP: begin
                cmd.step  = 1'b1;
                step_next = step_reg + 1'b1;
                if (step_reg == step_limit - 1'b1) begin
                    state_next = ST_STORE;
                end
            end
            ST_STORE: begin
                cmd.store  = 1'b1;
                state_next = ST_LOAD;
                unique case (op_reg)
                    OP_MEAN:     op_next = OP_SQ_MUL;
                    OP_SQ_MUL:   op_next = OP_NSQ_MUL;
                    OP_NSQ_MUL:  op_next = OP_VAR_DIV1;
                    OP_VAR_DIV1: op_next = OP_VAR_DIV2;
                    OP_VAR_DIV2: op_next = OP_SQRT;
                    OP_SQRT: begin
                        if (chan_reg == CH_BLUE) begin
                            op_next = OP_RATIO_R;
                        end else begin
                            op_next   = OP_MEAN;
                            chan_next = chan_reg + 1'b1;
                        end
                    end
                    OP_RATIO_R:  op_next = OP_RATIO_B;
                    default:     state_next = ST_EMIT;
                endcase
            end
            ST_EMIT: begin
                if (out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            op_reg    <= OP_MEAN;
            chan_reg  <= CH_RED;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            op_reg    <= op_next;
            chan_reg  <= chan_next;
            step_reg  <= step_next;
        end
    end

    a_step_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_STEP |-> step_reg < step_limit)
        else $error("step counter ran past the unit length");

endmodule

>>> design/rmms_dp.sv
// ----------------------------------------------------------------------------
// rmms_dp
// region test, accumulators and shared iterative multiplier, divider and square root
// ----------------------------------------------------------------------------
module rmms_dp import rmms_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  rmms_cfg_t          cfg,
    input  logic               pix_en,
    input  logic [PIX_W-1:0]   chan_a,
    input  logic [PIX_W-1:0]   chan_b,
    input  logic [PIX_W-1:0]   chan_c,
    input  logic [COORD_W-1:0] col,
    input  logic [COORD_W-1:0] row,
    input  rmms_cmd_t          cmd,
    output rmms_result_t       result
);

    logic [SUM_W-1:0]  sum_r_reg, sum_g_reg, sum_b_reg;
    logic [SQ_W-1:0]   sq_r_reg, sq_g_reg, sq_b_reg;
    logic [CNT_W-1:0]  cnt_reg;

    logic signed [ROI_W+1:0] col_s, row_s, x_lo, y_lo, x_hi, y_hi;
    logic                    in_roi;
    logic [PIX_W-1:0]        pr, pg, pb;
    logic [2*PIX_W-1:0]      pr2, pg2, pb2;

    // region test, wide enough for negative origins
    assign col_s  = $signed({3'b000, col});
    assign row_s  = $signed({3'b000, row});
    assign x_lo   = $signed({{2{cfg.roi_x[ROI_W-1]}}, cfg.roi_x});
    assign y_lo   = $signed({{2{cfg.roi_y[ROI_W-1]}}, cfg.roi_y});
    assign x_hi   = x_lo + $signed({2'b00, cfg.roi_width});
    assign y_hi   = y_lo + $signed({2'b00, cfg.roi_height});
    assign in_roi = (col_s >= x_lo) && (col_s < x_hi) && (row_s >= y_lo) && (row_s < y_hi);

    always_comb begin
        case (cfg.pixel_format)
            FMT_GRAY: begin pr = chan_a; pg = chan_a; pb = chan_a; end
            FMT_BGR:  begin pr = chan_c; pg = chan_b; pb = chan_a; end
            default:  begin pr = chan_a; pg = chan_b; pb = chan_c; end
        endcase
    end

    assign pr2 = pr * pr;
    assign pg2 = pg * pg;
    assign pb2 = pb * pb;

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.emit) begin
            sum_r_reg <= '0;
            sum_g_reg <= '0;
            sum_b_reg <= '0;
            sq_r_reg  <= '0;
            sq_g_reg  <= '0;
            sq_b_reg  <= '0;
            cnt_reg   <= '0;
        end else if (pix_en && in_roi && !cnt_reg[CNT_W-1]) begin
            sum_r_reg <= sum_r_reg + SUM_W'(pr);
            sum_g_reg <= sum_g_reg + SUM_W'(pg);
            sum_b_reg <= sum_b_reg + SUM_W'(pb);
            sq_r_reg  <= sq_r_reg + SQ_W'(pr2);
            sq_g_reg  <= sq_g_reg + SQ_W'(pg2);
            sq_b_reg  <= sq_b_reg + SQ_W'(pb2);
            cnt_reg   <= cnt_reg + 1'b1;
        end
    end

    // operand select
    logic [SUM_W-1:0]  sel_sum;
    logic [SQ_W-1:0]   sel_sq;
    logic [DIVS_W-1:0] divisor;
    logic [DIVD_W-1:0] div_load;

    always_comb begin
        case (cmd.chan)
            CH_RED:   begin sel_sum = sum_r_reg; sel_sq = sq_r_reg; end
            CH_GREEN: begin sel_sum = sum_g_reg; sel_sq = sq_g_reg; end
            default:  begin sel_sum = sum_b_reg; sel_sq = sq_b_reg; end
        endcase
    end

    logic [PROD_W-1:0] b_reg, d_reg, t_reg;
    logic [ROOT_W-1:0] v_reg;

    always_comb begin
        divisor = DIVS_W'(cnt_reg);
        case (cmd.op)
            OP_MEAN:     div_load = DIVD_W'({sel_sum, 8'h00});
            OP_VAR_DIV1: div_load = {d_reg, 16'h0000};
            OP_VAR_DIV2: div_load = DIVD_W'(t_reg);
            OP_RATIO_R: begin
                div_load = DIVD_W'({sum_r_reg, 16'h0000});
                divisor  = sum_g_reg;
            end
            OP_RATIO_B: begin
                div_load = DIVD_W'({sum_b_reg, 16'h0000});
                divisor  = sum_g_reg;
            end
            default:     div_load = '0;
        endcase
    end

    // restoring divider, one quotient bit a step
    logic [DIVS_W-1:0] div_rem_reg;
    logic [DIVD_W-1:0] div_q_reg;
    logic [DIVS_W:0]   rem_sh, rem_sub;
    logic              rem_ge;

    assign rem_sh  = {div_rem_reg, div_q_reg[DIVD_W-1]};
    assign rem_ge  = rem_sh >= {1'b0, divisor};
    assign rem_sub = rem_sh - {1'b0, divisor};

    // shift-add multiplier, one multiplier bit a step
    logic [PROD_W-1:0] mul_acc_reg, mul_mcand_reg;
    logic [SUM_W-1:0]  mul_mplier_reg;

    // bitwise integer square root, one result bit per step
    logic [ROOT_W-1:0] sq_x_reg, sq_res_reg, sq_bit_reg, sq_trial;

    assign sq_trial = sq_res_reg + sq_bit_reg;

    logic [MEAN_W-1:0]  mean_r_reg, mean_g_reg, mean_b_reg;
    logic [MEAN_W-1:0]  std_r_reg, std_g_reg, std_b_reg;
    logic [RATIO_W-1:0] rg_reg, bg_reg;
    logic [RATIO_W-1:0] ratio_sat;

    assign ratio_sat = (|div_q_reg[DIVD_W-1:RATIO_W]) ? '1 : div_q_reg[RATIO_W-1:0];

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            div_rem_reg <= '0;
            div_q_reg   <= div_load;
            mul_acc_reg <= '0;
            if (cmd.op == OP_NSQ_MUL) begin
                mul_mcand_reg  <= PROD_W'(sel_sq);
                mul_mplier_reg <= SUM_W'(cnt_reg);
            end else begin
                mul_mcand_reg  <= PROD_W'(sel_sum);
                mul_mplier_reg <= sel_sum;
            end
            sq_x_reg   <= v_reg;
            sq_res_reg <= '0;
            sq_bit_reg <= ROOT_W'(1) << (ROOT_W - 2);
        end else if (cmd.step) begin
            div_rem_reg <= rem_ge ? rem_sub[DIVS_W-1:0] : rem_sh[DIVS_W-1:0];
            div_q_reg   <= {div_q_reg[DIVD_W-2:0], rem_ge};
            if (mul_mplier_reg[0]) begin
                mul_acc_reg <= mul_acc_reg + mul_mcand_reg;
            end
            mul_mcand_reg  <= mul_mcand_reg << 1;
            mul_mplier_reg <= mul_mplier_reg >> 1;
            if (sq_x_reg >= sq_trial) begin
                sq_x_reg   <= sq_x_reg - sq_trial;
                sq_res_reg <= (sq_res_reg >> 1) + sq_bit_reg;
            end else begin
                sq_res_reg <= sq_res_reg >> 1;
            end
            sq_bit_reg <= sq_bit_reg >> 2;
        end
        if (cmd.store) begin
            case (cmd.op)
                OP_MEAN: begin
                    case (cmd.chan)
                        CH_RED:   mean_r_reg <= div_q_reg[MEAN_W-1:0];
                        CH_GREEN: mean_g_reg <= div_q_reg[MEAN_W-1:0];
                        default:  mean_b_reg <= div_q_reg[MEAN_W-1:0];
                    endcase
                end
                OP_SQ_MUL:   b_reg <= mul_acc_reg;
                OP_NSQ_MUL:  d_reg <= (mul_acc_reg > b_reg) ? mul_acc_reg - b_reg : '0;
                OP_VAR_DIV1: t_reg <= div_q_reg[PROD_W-1:0];
                OP_VAR_DIV2: v_reg <= div_q_reg[ROOT_W-1:0];
                OP_SQRT: begin
                    case (cmd.chan)
                        CH_RED:   std_r_reg <= sq_res_reg[MEAN_W-1:0];
                        CH_GREEN: std_g_reg <= sq_res_reg[MEAN_W-1:0];
                        default:  std_b_reg <= sq_res_reg[MEAN_W-1:0];
                    endcase
                end
                OP_RATIO_R:  rg_reg <= ratio_sat;
                default:     bg_reg <= ratio_sat;
            endcase
        end
    end

    // no pixel counted gives an all-zero result
    logic n_nz, g_nz;

    assign n_nz = |cnt_reg;
    assign g_nz = |sum_g_reg;

    always_comb begin
        result                 = '0;
        result.ok              = n_nz;
        result.ratios_valid    = n_nz && g_nz;
        result.pixel_total     = cnt_reg;
        if (n_nz) begin
            result.red_mean   = mean_r_reg;
            result.green_mean = mean_g_reg;
            result.blue_mean  = mean_b_reg;
            result.red_std    = std_r_reg;
            result.green_std  = std_g_reg;
            result.blue_std   = std_b_reg;
        end
        if (n_nz && g_nz) begin
            result.red_over_green  = rg_reg;
            result.blue_over_green = bg_reg;
        end
    end

    a_clear_after_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |=> cnt_reg == '0)
        else $error("accumulators not cleared after result");

    a_count_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cnt_reg[CNT_W-1] && (|cnt_reg[CNT_W-2:0])))
        else $error("pixel count ran past its cap");

endmodule
